### rtl/pbmtc_pkg.sv
// Shared types and constants for the PBM to tile converter.
// Depends on nothing; the files that use it refer to it by scoped names.
package pbmtc_pkg;

   localparam int ADDR_W = 18;

   // Characters that the header parser looks for
   localparam logic [7:0] CH_P       = 8'h50;  // 'P'
   localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
   localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
   localparam logic [7:0] CH_NL      = 8'h0a;  // '\n'
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] BYTE_ONES  = 8'hff;
   localparam logic [3:0] DIGIT_FOUR = 4'd4;
   localparam logic [3:0] DIGIT_ONE  = 4'd1;
   localparam logic [3:0] DIGIT_SIX  = 4'd6;

   // Status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BADCHAR     = 3'd1;
   localparam logic [2:0] ST_EARLY_END   = 3'd2;
   localparam logic [2:0] ST_ILLEGAL     = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ST_TRAILING    = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE   = 3'd6;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] tile_address;
      logic [7:0]        tile_byte;
      logic [2:0]        status;
      logic              finished;
   } rsp_word_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

### rtl/pbmtc_req_if.sv
// Input channel of the PBM to tile converter: one file byte or end marker.
// Depends on nothing.
interface pbmtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_marker;

   modport source (output valid, output data_byte, output end_marker, input ready);
   modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

### rtl/pbmtc_rsp_if.sv
// Result channel of the PBM to tile converter: tile store write or end status.
// Depends on pbmtc_pkg for the address width.
interface pbmtc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         write_valid;
   logic [pbmtc_pkg::ADDR_W-1:0] tile_address;
   logic [7:0]                   tile_byte;
   logic [2:0]                   status;
   logic                         finished;

   modport source (output valid, output write_valid, output tile_address,
                   output tile_byte, output status, output finished, input ready);
   modport sink   (input valid, input write_valid, input tile_address,
                   input tile_byte, input status, input finished, output ready);
endinterface

### rtl/pbmtc_out_skid.sv
// Two-entry output buffer (main register plus skid) for result words.
// Depends on pbmtc_pkg and pbmtc_rsp_if.
module pbmtc_out_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  pbmtc_pkg::rsp_word_type in_word,
   output logic                    in_ready,
   pbmtc_rsp_if.source             rsp_chan
);

   logic                    out_v_ff,  out_v_in;
   logic                    skid_v_ff, skid_v_in;
   pbmtc_pkg::rsp_word_type out_w_ff,  out_w_in;
   pbmtc_pkg::rsp_word_type skid_w_ff, skid_w_in;
   logic                    pop;

   assign pop      = out_v_ff && rsp_chan.ready;
   assign in_ready = !skid_v_ff;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_w_in  = out_w_ff;
      skid_w_in = skid_w_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_w_in  = skid_w_ff;
            skid_v_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_v_ff || pop) begin
            out_w_in = in_word;
            out_v_in = 1'b1;
         end else begin
            skid_w_in = in_word;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_w_ff  <= out_w_in;
      skid_w_ff <= skid_w_in;
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.write_valid  = out_w_ff.write_valid;
   assign rsp_chan.tile_address = out_w_ff.tile_address;
   assign rsp_chan.tile_byte    = out_w_ff.tile_byte;
   assign rsp_chan.status       = out_w_ff.status;
   assign rsp_chan.finished     = out_w_ff.finished;

`ifndef SYNTHESIS
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held while main register empty");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && pop |=> out_v_ff && !skid_v_ff)
      else $error("skid word not moved to main register");
`endif

endmodule

### rtl/pbm_to_tile_converter.sv
// Top level of the PBM (P4) to 8x8 tile pattern converter.
// Depends on pbmtc_pkg, pbmtc_req_if, pbmtc_rsp_if and pbmtc_out_skid.
//
//   channel   | dir | word contents                                     | notes
//   ----------+-----+---------------------------------------------------+-----------------
//   req_chan  | in  | data_byte, end_marker                             | one file byte
//   rsp_chan  | out | write_valid, tile_address, tile_byte, status,     | zero or one per
//             |     | finished                                          | input word
//
// Each word is parsed in the cycle it is accepted and its result is registered
// in the output buffer; one word per cycle is sustained while rsp_chan does not
// stall. The header parser and raster counters update in a single pass.
// A two-entry output buffer decouples the sides: req_chan.ready drops only
// while both entries are full, i.e. after rsp_chan has stalled for two results.
// Synchronous reset returns the parser to the magic letter and empties the
// buffer; the end marker word does the same for the parser after reporting.
module pbm_to_tile_converter #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   pbmtc_req_if.sink    req_chan,
   pbmtc_rsp_if.source  rsp_chan
);

   localparam int ACC_CAP  = ((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1;
   localparam int ACC_W    = $clog2(ACC_CAP + 1);
   localparam int MUL_W    = ACC_W + 4;
   localparam int COLS_MAX = (MAX_WIDTH + 7) / 8;
   localparam int COL_W    = $clog2(COLS_MAX + 1);
   localparam int ROWS_MAX = (MAX_HEIGHT + 7) / 8;
   localparam int ROW_W    = $clog2(ROWS_MAX + 1);
   localparam int AW       = pbmtc_pkg::ADDR_W;

   typedef enum logic [3:0] {
      PH_MAGIC_P,
      PH_MAGIC_DIGIT,
      PH_SEP1_FIRST,
      PH_SEP1_MORE,
      PH_WIDTH,
      PH_SEP2_MORE,
      PH_HEIGHT,
      PH_RASTER,
      PH_DONE
   } phase_type;

   // Parser control
   phase_type  phase_ff, phase_in;
   logic [2:0] err_ff, err_in;
   logic       in_comment_ff, in_comment_in;
   // Header values and raster counters
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] width_ff, width_in;
   logic [COL_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0] rows_ff, rows_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [2:0]       rit_ff, rit_in;
   logic [ROW_W-1:0] trow_ff, trow_in;
   logic [AW-1:0]    base_ff, base_in;

   logic                    accept;
   logic                    skid_ready;
   logic                    push;
   pbmtc_pkg::rsp_word_type word;
   logic [7:0]              c;
   logic [3:0]              digit;
   logic [MUL_W-1:0]        acc_next;
   logic [ACC_W-1:0]        acc_sat;
   logic [ACC_W:0]          width_round;
   logic [ACC_W:0]          height_round;

   assign req_chan.ready = skid_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.data_byte;
   assign digit          = 4'(c - pbmtc_pkg::CH_ZERO);

   // Decimal accumulate: acc*10 + digit, saturating at the cap
   assign acc_next = MUL_W'({acc_ff, 3'b000}) + MUL_W'({acc_ff, 1'b0}) + MUL_W'(digit);
   assign acc_sat  = (acc_next > MUL_W'(ACC_CAP)) ? ACC_W'(ACC_CAP) : acc_next[ACC_W-1:0];

   assign width_round  = {1'b0, width_ff} + (ACC_W+1)'(7);
   assign height_round = {1'b0, acc_ff} + (ACC_W+1)'(7);

   always_comb begin
      phase_in      = phase_ff;
      err_in        = err_ff;
      in_comment_in = in_comment_ff;
      acc_in        = acc_ff;
      width_in      = width_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      col_in        = col_ff;
      rit_in        = rit_ff;
      trow_in       = trow_ff;
      base_in       = base_ff;
      push          = 1'b0;
      word          = '0;

      if (accept) begin
         if (req_chan.end_marker) begin
            // Report final status, then start over on the next file
            push          = 1'b1;
            word.finished = 1'b1;
            if (err_ff != pbmtc_pkg::ST_OK) begin
               word.status = err_ff;
            end else if (phase_ff != PH_DONE) begin
               word.status = pbmtc_pkg::ST_EARLY_END;
            end else begin
               word.status = pbmtc_pkg::ST_OK;
            end
            phase_in      = PH_MAGIC_P;
            err_in        = pbmtc_pkg::ST_OK;
            in_comment_in = 1'b0;
            acc_in        = '0;
         end else if (err_ff == pbmtc_pkg::ST_OK) begin
            unique case (phase_ff)
               PH_MAGIC_P: begin
                  if (c == pbmtc_pkg::CH_P) begin
                     phase_in = PH_MAGIC_DIGIT;
                  end else begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end
               end
               PH_MAGIC_DIGIT: begin
                  if (!pbmtc_pkg::is_dec(c)) begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end else if (digit == pbmtc_pkg::DIGIT_FOUR) begin
                     phase_in = PH_SEP1_FIRST;
                  end else if (digit >= pbmtc_pkg::DIGIT_ONE &&
                               digit <= pbmtc_pkg::DIGIT_SIX) begin
                     err_in = pbmtc_pkg::ST_UNSUPPORTED;
                  end else begin
                     err_in = pbmtc_pkg::ST_ILLEGAL;
                  end
               end
               PH_SEP1_FIRST: begin
                  if (pbmtc_pkg::is_ws(c)) begin
                     phase_in = PH_SEP1_MORE;
                  end else if (c == pbmtc_pkg::CH_HASH) begin
                     in_comment_in = 1'b1;
                     phase_in      = PH_SEP1_MORE;
                  end else begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end
               end
               PH_SEP1_MORE, PH_SEP2_MORE: begin
                  // Skip blanks and comments until a number starts
                  if (in_comment_ff) begin
                     if (c == pbmtc_pkg::CH_NL) begin
                        in_comment_in = 1'b0;
                     end
                  end else if (pbmtc_pkg::is_ws(c)) begin
                     in_comment_in = 1'b0;
                  end else if (c == pbmtc_pkg::CH_HASH) begin
                     in_comment_in = 1'b1;
                  end else if (pbmtc_pkg::is_dec(c)) begin
                     acc_in   = ACC_W'(digit);
                     phase_in = (phase_ff == PH_SEP1_MORE) ? PH_WIDTH : PH_HEIGHT;
                  end else begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end
               end
               PH_WIDTH: begin
                  if (pbmtc_pkg::is_dec(c)) begin
                     acc_in = acc_sat;
                  end else if (pbmtc_pkg::is_ws(c) || c == pbmtc_pkg::CH_HASH) begin
                     width_in      = acc_ff;
                     acc_in        = '0;
                     in_comment_in = (c == pbmtc_pkg::CH_HASH);
                     phase_in      = PH_SEP2_MORE;
                  end else begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end
               end
               PH_HEIGHT: begin
                  if (pbmtc_pkg::is_dec(c)) begin
                     acc_in = acc_sat;
                  end else if (pbmtc_pkg::is_ws(c)) begin
                     // Header complete: check dimensions, set up raster counters
                     if (width_ff == '0 || acc_ff == '0) begin
                        err_in = pbmtc_pkg::ST_ILLEGAL;
                     end else if (width_ff > ACC_W'(MAX_WIDTH) ||
                                  acc_ff > ACC_W'(MAX_HEIGHT)) begin
                        err_in = pbmtc_pkg::ST_TOO_LARGE;
                     end else begin
                        cols_in  = COL_W'(width_round >> 3);
                        rows_in  = ROW_W'(height_round >> 3);
                        col_in   = '0;
                        rit_in   = '0;
                        trow_in  = '0;
                        base_in  = '0;
                        phase_in = PH_RASTER;
                     end
                  end else begin
                     err_in = pbmtc_pkg::ST_BADCHAR;
                  end
               end
               PH_RASTER: begin
                  push              = 1'b1;
                  word.write_valid  = 1'b1;
                  word.tile_address = base_ff + AW'({col_ff, 3'b000}) + AW'(rit_ff);
                  word.tile_byte    = c ^ pbmtc_pkg::BYTE_ONES;
                  word.status       = pbmtc_pkg::ST_OK;
                  // Advance column, then row in tile, then tile row
                  if (col_ff + COL_W'(1) == cols_ff) begin
                     col_in = '0;
                     rit_in = rit_ff + 3'd1;
                     if (rit_ff == 3'd7) begin
                        trow_in = trow_ff + ROW_W'(1);
                        base_in = base_ff + AW'({cols_ff, 3'b000});
                        if (trow_ff + ROW_W'(1) == rows_ff) begin
                           phase_in = PH_DONE;
                        end
                     end
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
               PH_DONE: begin
                  err_in = pbmtc_pkg::ST_TRAILING;
               end
               default: begin
                  err_in = pbmtc_pkg::ST_ILLEGAL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC_P;
         err_ff        <= pbmtc_pkg::ST_OK;
         in_comment_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         err_ff        <= err_in;
         in_comment_ff <= in_comment_in;
      end
      acc_ff   <= acc_in;
      width_ff <= width_in;
      cols_ff  <= cols_in;
      rows_ff  <= rows_in;
      col_ff   <= col_in;
      rit_ff   <= rit_in;
      trow_ff  <= trow_in;
      base_ff  <= base_in;
   end

   pbmtc_out_skid u_out_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push),
      .in_word  (word),
      .in_ready (skid_ready),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_marker |=>
         phase_ff == PH_MAGIC_P && err_ff == pbmtc_pkg::ST_OK)
      else $error("end marker did not return parser to start");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      err_ff != pbmtc_pkg::ST_OK && !(accept && req_chan.end_marker) |=>
         err_ff == $past(err_ff))
      else $error("held error changed before end marker");

   a_raster_bounds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RASTER |-> col_ff < cols_ff && trow_ff < rows_ff)
      else $error("raster counters out of range");

   a_status_on_end_only: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != pbmtc_pkg::ST_OK |->
         rsp_chan.finished && !rsp_chan.write_valid)
      else $error("error status on a tile write");
`endif

endmodule

### sim/pbmtc_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the PBM to tile converter: header parser, raster address
// tracker and the queue of awaited output words. Depends on pbmtc_pkg.
package pbmtc_tb_pkg;

   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;
   localparam int unsigned ACC_CAP    =
      ((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1;
   localparam int unsigned PRINT_CAP  = 40;

   typedef enum logic [3:0] {
      PH_MAGIC_P, PH_MAGIC_DIGIT, PH_SEP1_FIRST, PH_SEP1_MORE, PH_WIDTH,
      PH_SEP2_MORE, PH_HEIGHT, PH_RASTER, PH_DONE
   } parse_phase_type;

   // Kinds of generated files; the error kinds come first, FK_GOOD last
   typedef enum int {
      FK_EARLY_END, FK_TRAILING, FK_BAD_LETTER, FK_BAD_DIGIT, FK_BAD_SEPARATOR,
      FK_BAD_NUMBER_CHAR, FK_HASH_AFTER_HEIGHT, FK_ZERO_SIZE, FK_TOO_LARGE,
      FK_NOISE, FK_EMPTY, FK_GOOD
   } file_kind_type;

   function automatic bit is_space(logic [7:0] c);
      return (c == pbmtc_pkg::CH_SPACE) ||
             ((c >= pbmtc_pkg::CH_TAB) && (c <= pbmtc_pkg::CH_CR));
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return (c >= pbmtc_pkg::CH_ZERO) && (c <= pbmtc_pkg::CH_NINE);
   endfunction

   class tile_table_scoreboard;
      parse_phase_type phase;
      int unsigned  number_acc;
      bit           in_comment;
      int unsigned  tile_cols;
      int unsigned  tile_rows;
      int unsigned  tile_row_idx;
      int unsigned  row_in_tile;
      int unsigned  col_idx;
      int unsigned  row_base;
      logic [2:0]   held_status;
      pbmtc_pkg::rsp_word_type awaited_words[$];
      int unsigned  error_count;

      function new();
         error_count = 0;
         restart_file();
      endfunction

      function void restart_file();
         phase        = PH_MAGIC_P;
         number_acc   = 0;
         in_comment   = 1'b0;
         tile_cols    = 0;
         tile_rows    = 0;
         tile_row_idx = 0;
         row_in_tile  = 0;
         col_idx      = 0;
         row_base     = 0;
         held_status  = pbmtc_pkg::ST_OK;
      endfunction

      function int unsigned pending();
         return awaited_words.size();
      endfunction

      // Shift one decimal digit in, saturating just above the larger bound
      function void push_digit(logic [7:0] c);
         int unsigned v;
         v = number_acc * 10 + (c - pbmtc_pkg::CH_ZERO);
         number_acc = (v > ACC_CAP) ? ACC_CAP : v;
      endfunction

      function void separator_step(logic [7:0] c, parse_phase_type next_phase);
         if (in_comment) begin
            if (c == pbmtc_pkg::CH_NL) in_comment = 1'b0;
         end else if (is_space(c)) begin
         end else if (c == pbmtc_pkg::CH_HASH) begin
            in_comment = 1'b1;
         end else if (is_digit(c)) begin
            number_acc = 0;
            push_digit(c);
            phase = next_phase;
         end else begin
            held_status = pbmtc_pkg::ST_BADCHAR;
         end
      endfunction

      function void close_header();
         int unsigned w;
         int unsigned h;
         w = tile_cols;
         h = number_acc;
         if (w == 0 || h == 0) begin
            held_status = pbmtc_pkg::ST_ILLEGAL;
         end else if (w > MAX_WIDTH || h > MAX_HEIGHT) begin
            held_status = pbmtc_pkg::ST_TOO_LARGE;
         end else begin
            tile_cols    = (w + 7) / 8;
            tile_rows    = (h + 7) / 8;
            tile_row_idx = 0;
            row_in_tile  = 0;
            col_idx      = 0;
            row_base     = 0;
            phase        = PH_RASTER;
         end
      endfunction

      // Note one accepted input word; returns 0 when the block ignores it
      function bit take_file_word(logic [7:0] c, logic end_word);
         pbmtc_pkg::rsp_word_type w;
         int unsigned             addr;
         logic [3:0]              d;
         w = '0;
         if (end_word) begin
            w.status = held_status;
            if (held_status == pbmtc_pkg::ST_OK && phase != PH_DONE)
               w.status = pbmtc_pkg::ST_EARLY_END;
            w.finished = 1'b1;
            awaited_words.push_back(w);
            restart_file();
            return 1'b1;
         end
         if (held_status != pbmtc_pkg::ST_OK) return 1'b0;
         case (phase)
            PH_MAGIC_P: begin
               if (c == pbmtc_pkg::CH_P) phase = PH_MAGIC_DIGIT;
               else held_status = pbmtc_pkg::ST_BADCHAR;
            end
            PH_MAGIC_DIGIT: begin
               d = 4'(c - pbmtc_pkg::CH_ZERO);
               if (!is_digit(c)) held_status = pbmtc_pkg::ST_BADCHAR;
               else if (d == pbmtc_pkg::DIGIT_FOUR) phase = PH_SEP1_FIRST;
               else if (d >= pbmtc_pkg::DIGIT_ONE && d <= pbmtc_pkg::DIGIT_SIX)
                  held_status = pbmtc_pkg::ST_UNSUPPORTED;
               else held_status = pbmtc_pkg::ST_ILLEGAL;
            end
            PH_SEP1_FIRST: begin
               if (is_space(c)) begin
                  phase = PH_SEP1_MORE;
               end else if (c == pbmtc_pkg::CH_HASH) begin
                  in_comment = 1'b1;
                  phase = PH_SEP1_MORE;
               end else begin
                  held_status = pbmtc_pkg::ST_BADCHAR;
               end
            end
            PH_SEP1_MORE: separator_step(c, PH_WIDTH);
            PH_WIDTH: begin
               if (is_digit(c)) begin
                  push_digit(c);
               end else if (is_space(c) || c == pbmtc_pkg::CH_HASH) begin
                  tile_cols  = number_acc;
                  number_acc = 0;
                  in_comment = (c == pbmtc_pkg::CH_HASH);
                  phase      = PH_SEP2_MORE;
               end else begin
                  held_status = pbmtc_pkg::ST_BADCHAR;
               end
            end
            PH_SEP2_MORE: separator_step(c, PH_HEIGHT);
            PH_HEIGHT: begin
               if (is_digit(c)) push_digit(c);
               else if (is_space(c)) close_header();
               else held_status = pbmtc_pkg::ST_BADCHAR;
            end
            PH_RASTER: begin
               addr = row_base + 8 * col_idx + row_in_tile;
               w.write_valid  = 1'b1;
               w.tile_address = addr[pbmtc_pkg::ADDR_W-1:0];
               w.tile_byte    = ~c;
               awaited_words.push_back(w);
               col_idx++;
               if (col_idx >= tile_cols) begin
                  col_idx = 0;
                  row_in_tile++;
                  if (row_in_tile >= 8) begin
                     row_in_tile = 0;
                     tile_row_idx++;
                     row_base += 8 * tile_cols;
                     if (tile_row_idx >= tile_rows) phase = PH_DONE;
                  end
               end
            end
            PH_DONE: held_status = pbmtc_pkg::ST_TRAILING;
            default: held_status = pbmtc_pkg::ST_ILLEGAL;
         endcase
         return 1'b1;
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= PRINT_CAP) $display("mismatch: %s", msg);
      endtask

      // Compare one output word, field by field, with the oldest awaited one
      task match_output_word(pbmtc_pkg::rsp_word_type got);
         pbmtc_pkg::rsp_word_type want;
         if (awaited_words.size() == 0) begin
            report_mismatch($sformatf("unexpected output word %h", got));
            return;
         end
         want = awaited_words.pop_front();
         if (got.write_valid !== want.write_valid)
            report_mismatch($sformatf("write_valid %b, want %b",
                                      got.write_valid, want.write_valid));
         if (got.tile_address !== want.tile_address)
            report_mismatch($sformatf("tile_address %h, want %h",
                                      got.tile_address, want.tile_address));
         if (got.tile_byte !== want.tile_byte)
            report_mismatch($sformatf("tile_byte %h, want %h (address %h)",
                                      got.tile_byte, want.tile_byte, want.tile_address));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.finished !== want.finished)
            report_mismatch($sformatf("finished %b, want %b",
                                      got.finished, want.finished));
      endtask
   endclass

endpackage

### sim/tb_pbm_to_tile_converter.sv
`timescale 1ns / 1ps
// Top of the PBM to tile converter testbench: clock, reset, file generator,
// word driver and result sink. Depends on pbmtc_pkg, pbmtc_tb_pkg and the RTL.
module tb_pbm_to_tile_converter;

   localparam int          HALF_PERIOD_NS = 2;
   localparam int          RESET_CYCLES   = 8;
   localparam int unsigned RANDOM_WORDS   = 400;
   localparam int unsigned LONG_HOLD      = 200;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT    = 1500000;
   localparam int          NUM_ERROR_KINDS = int'(pbmtc_tb_pkg::FK_GOOD);

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned words_sent;
   bit          idle_on;
   bit          hold_request;
   logic [7:0]  file_bytes[$];

   pbmtc_tb_pkg::tile_table_scoreboard tiles = new();

   pbmtc_req_if req_chan ();
   pbmtc_rsp_if rsp_chan ();

   pbm_to_tile_converter #(
      .MAX_WIDTH  (pbmtc_tb_pkg::MAX_WIDTH),
      .MAX_HEIGHT (pbmtc_tb_pkg::MAX_HEIGHT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Watchdog: end the run if the block hangs or drops words
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL pbm_to_tile_converter");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // File generator: each helper appends bytes to file_bytes
   // ---------------------------------------------------------------------

   // Pick one of the six whitespace bytes
   function automatic logic [7:0] space_byte();
      int unsigned r;
      r = $urandom_range(0, 5);
      return (r == 5) ? pbmtc_pkg::CH_SPACE : 8'(pbmtc_pkg::CH_TAB + r);
   endfunction

   // A byte that is neither whitespace, '#' nor a digit
   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (pbmtc_tb_pkg::is_space(b) || pbmtc_tb_pkg::is_digit(b) ||
             b == pbmtc_pkg::CH_HASH);
      return b;
   endfunction

   function automatic void add_noise(int unsigned n);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Comment body may hold any byte except the newline that closes it
   function automatic void add_comment();
      logic [7:0] b;
      file_bytes.push_back(pbmtc_pkg::CH_HASH);
      repeat ($urandom_range(0, 4)) begin
         do b = 8'($urandom_range(0, 255)); while (b == pbmtc_pkg::CH_NL);
         file_bytes.push_back(b);
      end
      file_bytes.push_back(pbmtc_pkg::CH_NL);
   endfunction

   // Separator run: one to three pieces, each whitespace or a comment
   function automatic void add_gap();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 3) == 0) add_comment();
         else file_bytes.push_back(space_byte());
      end
   endfunction

   function automatic void add_number(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) file_bytes.push_back(pbmtc_pkg::CH_ZERO);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(8'(s[i]));
   endfunction

   // Magic, width and height; the single byte after the height is left out
   function automatic void add_header(int unsigned w, int unsigned h);
      file_bytes.push_back(pbmtc_pkg::CH_P);
      file_bytes.push_back(8'(pbmtc_pkg::CH_ZERO + pbmtc_pkg::DIGIT_FOUR));
      add_gap();
      add_number(w);
      add_gap();
      add_number(h);
   endfunction

   function automatic void add_raster(int unsigned n);
      int unsigned r;
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r == 0) file_bytes.push_back(8'h00);
         else if (r == 1) file_bytes.push_back(8'hff);
         else file_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic int unsigned raster_size(int unsigned w, int unsigned h);
      return 8 * ((w + 7) / 8) * ((h + 7) / 8);
   endfunction

   function automatic void build_file(pbmtc_tb_pkg::file_kind_type kind);
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned cut;
      int unsigned r;
      logic [7:0]  b;
      w = $urandom_range(1, 20);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      n = raster_size(w, h);
      r = $urandom_range(0, 2);
      case (kind)
         pbmtc_tb_pkg::FK_GOOD, pbmtc_tb_pkg::FK_EARLY_END,
         pbmtc_tb_pkg::FK_TRAILING: begin
            add_header(w, h);
            file_bytes.push_back(space_byte());
            add_raster(n);
            if (kind == pbmtc_tb_pkg::FK_EARLY_END) begin
               // Mostly cut inside the raster, now and then anywhere
               if ($urandom_range(0, 3) == 0) cut = $urandom_range(0, file_bytes.size() - 1);
               else cut = file_bytes.size() - $urandom_range(1, n);
               while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
            if (kind == pbmtc_tb_pkg::FK_TRAILING) add_noise($urandom_range(1, 3));
         end
         pbmtc_tb_pkg::FK_BAD_LETTER: begin
            do b = 8'($urandom_range(0, 255)); while (b == pbmtc_pkg::CH_P);
            file_bytes.push_back(b);
            add_noise($urandom_range(0, 4));
         end
         pbmtc_tb_pkg::FK_BAD_DIGIT: begin
            file_bytes.push_back(pbmtc_pkg::CH_P);
            if ($urandom_range(0, 2) != 0) begin
               cut = $urandom_range(0, 8);
               if (cut >= pbmtc_pkg::DIGIT_FOUR) cut++;
               b = 8'(pbmtc_pkg::CH_ZERO + cut);
            end else begin
               do b = 8'($urandom_range(0, 255));
               while (b == 8'(pbmtc_pkg::CH_ZERO + pbmtc_pkg::DIGIT_FOUR));
            end
            file_bytes.push_back(b);
            add_noise($urandom_range(0, 4));
         end
         pbmtc_tb_pkg::FK_BAD_SEPARATOR: begin
            file_bytes.push_back(pbmtc_pkg::CH_P);
            file_bytes.push_back(8'(pbmtc_pkg::CH_ZERO + pbmtc_pkg::DIGIT_FOUR));
            do b = 8'($urandom_range(0, 255));
            while (pbmtc_tb_pkg::is_space(b) || b == pbmtc_pkg::CH_HASH);
            file_bytes.push_back(b);
            add_noise($urandom_range(0, 4));
         end
         pbmtc_tb_pkg::FK_BAD_NUMBER_CHAR: begin
            // Stray byte inside the width, in a separator run, or in the height
            file_bytes.push_back(pbmtc_pkg::CH_P);
            file_bytes.push_back(8'(pbmtc_pkg::CH_ZERO + pbmtc_pkg::DIGIT_FOUR));
            add_gap();
            if (r != 1) add_number(w);
            if (r == 2) begin
               add_gap();
               add_number(h);
            end
            file_bytes.push_back(stray_byte());
            add_noise($urandom_range(0, 4));
         end
         pbmtc_tb_pkg::FK_HASH_AFTER_HEIGHT: begin
            add_header(w, h);
            file_bytes.push_back(pbmtc_pkg::CH_HASH);
            add_noise($urandom_range(0, 4));
         end
         pbmtc_tb_pkg::FK_ZERO_SIZE: begin
            if (r != 1) w = 0;
            if (r != 0) h = 0;
            add_header(w, h);
            file_bytes.push_back(space_byte());
            add_raster($urandom_range(0, 8));
         end
         pbmtc_tb_pkg::FK_TOO_LARGE: begin
            // Long numbers saturate in the parser and still count as too large
            if (r != 1) w = $urandom_range(pbmtc_tb_pkg::MAX_WIDTH + 1,
                                           (r == 0) ? pbmtc_tb_pkg::MAX_WIDTH + 8 : 999999999);
            if (r != 0) h = $urandom_range(pbmtc_tb_pkg::MAX_HEIGHT + 1, 99999);
            add_header(w, h);
            file_bytes.push_back(space_byte());
            add_raster($urandom_range(0, 8));
         end
         pbmtc_tb_pkg::FK_NOISE: add_noise($urandom_range(1, 10));
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Word driver
   // ---------------------------------------------------------------------

   // Offer one word, hold it until accepted, then maybe drop valid a while.
   // Valid stays high between back-to-back words so it is never lowered and
   // raised in the same step.
   task automatic send_word(input logic [7:0] b, input logic end_word);
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.end_marker <= end_word;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      if (tiles.take_file_word(b, end_word)) words_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Send the generated bytes, then the end marker with a junk data byte
   task automatic send_file(input logic [7:0] junk);
      foreach (file_bytes[i]) send_word(file_bytes[i], 1'b0);
      send_word(junk, 1'b1);
      file_bytes.delete();
   endtask

   // ---------------------------------------------------------------------
   // Result sink: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            tiles.match_output_word(pbmtc_pkg::rsp_word_type'({
               rsp_chan.write_valid, rsp_chan.tile_address, rsp_chan.tile_byte,
               rsp_chan.status, rsp_chan.finished}));
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            // Hold off long enough for the output buffer to fill and stall req_chan
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned kind_offset;
      int unsigned file_no;
      pbmtc_tb_pkg::file_kind_type kind;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.end_marker <= 1'b0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      words_sent   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Smallest legal image: one column, one tile row, data extremes
      file_bytes = '{pbmtc_pkg::CH_P, 8'(pbmtc_pkg::CH_ZERO + pbmtc_pkg::DIGIT_FOUR),
                     pbmtc_pkg::CH_NL, 8'(pbmtc_pkg::CH_ZERO + 1), pbmtc_pkg::CH_SPACE,
                     8'(pbmtc_pkg::CH_ZERO + 1), pbmtc_pkg::CH_NL,
                     8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe};
      send_file(8'hff);
      // Unsupported magic digit, illegal magic digit, empty file
      file_bytes = '{pbmtc_pkg::CH_P, 8'(pbmtc_pkg::CH_ZERO + 5)};
      send_file(8'h00);
      file_bytes = '{pbmtc_pkg::CH_P, pbmtc_pkg::CH_ZERO};
      send_file(8'h5a);
      send_file(8'ha5);

      // Random files: every other one well formed, the rest walk through
      // the error kinds from a random starting point
      words_sent  = 0;
      file_no     = 0;
      kind_offset = $urandom_range(0, NUM_ERROR_KINDS - 1);
      while (words_sent < RANDOM_WORDS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (file_no % 2 == 0) kind = pbmtc_tb_pkg::FK_GOOD;
         else kind = pbmtc_tb_pkg::file_kind_type'((file_no / 2 + kind_offset) %
                                                   NUM_ERROR_KINDS);
         // Ask for the long receiver hold-off while a good file streams in
         if (file_no == 6) hold_request = 1'b1;
         // Pause the sender until every awaited word has come out
         if (file_no == 11) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (tiles.pending() != 0) @(posedge clock);
         end
         build_file(kind);
         send_file(8'($urandom_range(0, 255)));
         file_no++;
      end

      // Last part, no idling: a couple of well-formed files back to back
      idle_on = 1'b0;
      repeat (2) begin
         build_file(pbmtc_tb_pkg::FK_GOOD);
         send_file(8'($urandom_range(0, 255)));
      end
      req_chan.valid <= 1'b0;

      // Drain; the watchdog catches words that never arrive
      while (tiles.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tiles.error_count == 0) $display("PASS pbm_to_tile_converter");
      else $display("FAIL pbm_to_tile_converter");
      $finish;
   end

endmodule
